// ----- src/scl_pkg.sv -----
package scl_pkg;

  localparam int unsigned TIME_W = 32;
  localparam int unsigned CFG_W  = 8;

  typedef enum logic [0:0] {
    CFG_OFFSET_BITS = 1'b0,
    CFG_HIT_LATENCY = 1'b1
  } cfg_idx_t;

  typedef enum logic [1:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_LOOKUP
  } scl_state_t;

  typedef struct packed {
    logic [31:0] address;
    logic [31:0] access_time;
    logic [15:0] lower_latency;
  } scl_in_t;

  typedef struct packed {
    logic        hit;
    logic [16:0] total_latency;
    logic [7:0]  set_index;
    logic [23:0] line_tag;
    logic [1:0]  filled_way;
    logic [31:0] hit_count;
    logic [31:0] miss_count;
  } scl_out_t;

endpackage

// ----- src/scl_row_ram.sv -----
module scl_row_ram #(
  parameter int unsigned ROW_W  = 8,
  parameter int unsigned ADDR_W = 8
) (
  input  logic              clk,
  input  logic              rd_en,
  input  logic [ADDR_W-1:0] rd_addr,
  output logic [ROW_W-1:0]  rd_data,
  input  logic              wr_en,
  input  logic [ADDR_W-1:0] wr_addr,
  input  logic [ROW_W-1:0]  wr_data
);

  logic [ROW_W-1:0] mem [0:(1 << ADDR_W)-1];
  logic [ROW_W-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

// ----- src/scl_way_select.sv -----
module scl_way_select #(
  parameter int unsigned WAYS  = 4,
  parameter int unsigned TAG_W = 24,
  parameter int unsigned WAY_W = 2
) (
  input  logic [WAYS-1:0]                    row_vld,
  input  logic [WAYS-1:0][TAG_W-1:0]         row_tag,
  input  logic [WAYS-1:0][scl_pkg::TIME_W-1:0] row_time,
  input  logic [TAG_W-1:0]                   tag,
  output logic                               sel_hit,
  output logic [WAY_W-1:0]                   sel_way
);

  import scl_pkg::*;

  localparam int unsigned LVL    = $clog2(WAYS);
  localparam int unsigned LEAVES = 1 << LVL;

  logic [WAY_W-1:0]  hit_way;
  logic              any_free;
  logic [WAY_W-1:0]  free_way;
  logic [TIME_W-1:0] node_time [1:2*LEAVES-1];
  logic [WAY_W-1:0]  node_idx  [1:2*LEAVES-1];

  // first matching way and first free way
  always_comb begin
    sel_hit  = 1'b0;
    hit_way  = '0;
    any_free = 1'b0;
    free_way = '0;
    for (int w = WAYS - 1; w >= 0; w--) begin
      if (row_vld[w] && (row_tag[w] == tag)) begin
        sel_hit = 1'b1;
        hit_way = WAY_W'(w);
      end
      if (!row_vld[w]) begin
        any_free = 1'b1;
        free_way = WAY_W'(w);
      end
    end
  end

  // oldest way; left wins ties, pad leaves never win
  for (genvar i = 0; i < LEAVES; i++) begin : g_leaf
    if (i < WAYS) begin : g_real
      assign node_time[LEAVES+i] = row_time[i];
    end else begin : g_pad
      assign node_time[LEAVES+i] = '1;
    end
    assign node_idx[LEAVES+i] = WAY_W'(i);
  end

  for (genvar n = 1; n < LEAVES; n++) begin : g_node
    always_comb begin
      if (node_time[2*n+1] < node_time[2*n]) begin
        node_time[n] = node_time[2*n+1];
        node_idx[n]  = node_idx[2*n+1];
      end else begin
        node_time[n] = node_time[2*n];
        node_idx[n]  = node_idx[2*n];
      end
    end
  end

  always_comb begin
    if (sel_hit) begin
      sel_way = hit_way;
    end else if (any_free) begin
      sel_way = free_way;
    end else begin
      sel_way = node_idx[1];
    end
  end

endmodule

// ----- src/set_associative_cache_lookup_unit.sv -----
// ST_IDLE takes a word and reads its set row; ST_LOOKUP resolves it, writes it
// back and registers its result strobe; busy covers the set read and write-back,
// so consecutive words to the same set never overlap in the row memory.
// Reset: synchronous; a clearing pass then writes all 2**floor(log2(SETS)) set
// rows (256 by default) invalid, one row a cycle, with busy high.
// The receiver cannot stall: out_valid is a single-cycle strobe.
module set_associative_cache_lookup_unit #(
  parameter int unsigned WAYS = 4,
  parameter int unsigned SETS = 256
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  output logic              busy,
  input  scl_pkg::scl_in_t  in_word,
  output logic              out_valid,
  output scl_pkg::scl_out_t out_word,
  input  logic              cfg_we,
  input  scl_pkg::cfg_idx_t cfg_index,
  input  logic [scl_pkg::CFG_W-1:0] cfg_data
);

  import scl_pkg::*;

  localparam int unsigned IDX_BITS = $clog2(SETS + 1) - 1;
  localparam int unsigned TAG_W    = 32 - IDX_BITS;
  localparam int unsigned WAY_W    = (WAYS > 1) ? $clog2(WAYS) : 1;
  localparam int unsigned ROW_W    = WAYS * (1 + TAG_W + TIME_W);

  scl_state_t state_r, state_nxt;
  logic [IDX_BITS-1:0] clr_row_r, clr_row_nxt;

  logic [3:0] offset_bits_r;
  logic [7:0] hit_latency_r;

  logic [IDX_BITS-1:0] set_r;
  logic [TAG_W-1:0]    tag_r;
  logic [TIME_W-1:0]   time_r;
  logic [15:0]         lower_r;

  logic [31:0] hit_cnt_r, hit_cnt_nxt;
  logic [31:0] miss_cnt_r, miss_cnt_nxt;
  logic        out_valid_r;
  scl_out_t    out_word_r, out_word_nxt;

  logic [31:0]         shifted;
  logic                rd_en;
  logic                wr_en;
  logic [IDX_BITS-1:0] wr_addr;
  logic [ROW_W-1:0]    wr_data;
  logic [ROW_W-1:0]    rd_data;

  logic [WAYS-1:0]              row_vld, upd_vld;
  logic [WAYS-1:0][TAG_W-1:0]   row_tag, upd_tag;
  logic [WAYS-1:0][TIME_W-1:0]  row_time, upd_time;
  logic                         sel_hit;
  logic [WAY_W-1:0]             sel_way;

  logic [16:0]          lat_sum;
  logic [IDX_BITS+7:0]  set_ext;
  logic [TAG_W+23:0]    tag_ext;
  logic [WAY_W+1:0]     way_ext;

  assign shifted = in_word.address >> offset_bits_r;
  assign busy    = (state_r != ST_IDLE);

  scl_row_ram #(
    .ROW_W (ROW_W),
    .ADDR_W(IDX_BITS)
  ) u_ram (
    .clk    (clk),
    .rd_en  (rd_en),
    .rd_addr(shifted[IDX_BITS-1:0]),
    .rd_data(rd_data),
    .wr_en  (wr_en),
    .wr_addr(wr_addr),
    .wr_data(wr_data)
  );

  assign {row_time, row_tag, row_vld} = rd_data;

  scl_way_select #(
    .WAYS (WAYS),
    .TAG_W(TAG_W),
    .WAY_W(WAY_W)
  ) u_sel (
    .row_vld (row_vld),
    .row_tag (row_tag),
    .row_time(row_time),
    .tag     (tag_r),
    .sel_hit (sel_hit),
    .sel_way (sel_way)
  );

  // hit and fill update the chosen way alike
  always_comb begin
    upd_vld  = row_vld;
    upd_tag  = row_tag;
    upd_time = row_time;
    upd_vld[sel_way]  = 1'b1;
    upd_tag[sel_way]  = tag_r;
    upd_time[sel_way] = time_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= ST_CLEAR;
      clr_row_r <= '0;
    end else begin
      state_r   <= state_nxt;
      clr_row_r <= clr_row_nxt;
    end
  end

  always_comb begin
    state_nxt   = state_r;
    clr_row_nxt = clr_row_r;
    rd_en       = 1'b0;
    wr_en       = 1'b0;
    wr_addr     = set_r;
    wr_data     = {upd_time, upd_tag, upd_vld};
    case (state_r)
      ST_CLEAR: begin
        wr_en       = 1'b1;
        wr_addr     = clr_row_r;
        wr_data     = '0;
        clr_row_nxt = clr_row_r + IDX_BITS'(1);
        if (&clr_row_r) begin
          state_nxt = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (start) begin
          rd_en     = 1'b1;
          state_nxt = ST_LOOKUP;
        end
      end
      ST_LOOKUP: begin
        wr_en     = 1'b1;
        state_nxt = ST_IDLE;
      end
      default: begin
        state_nxt = ST_CLEAR;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      offset_bits_r <= 4'd6;
      hit_latency_r <= 8'd1;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_OFFSET_BITS: offset_bits_r <= cfg_data[3:0];
        CFG_HIT_LATENCY: hit_latency_r <= cfg_data[7:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      set_r   <= shifted[IDX_BITS-1:0];
      tag_r   <= shifted[31:IDX_BITS];
      time_r  <= in_word.access_time;
      lower_r <= in_word.lower_latency;
    end
  end

  always_comb begin
    hit_cnt_nxt  = hit_cnt_r;
    miss_cnt_nxt = miss_cnt_r;
    if (state_r == ST_LOOKUP) begin
      if (sel_hit) begin
        if (hit_cnt_r != '1) begin
          hit_cnt_nxt = hit_cnt_r + 32'd1;
        end
      end else if (miss_cnt_r != '1) begin
        miss_cnt_nxt = miss_cnt_r + 32'd1;
      end
    end
  end

  assign lat_sum = {9'd0, hit_latency_r} + {1'b0, lower_r};
  assign set_ext = {8'd0, set_r};
  assign tag_ext = {24'd0, tag_r};
  assign way_ext = {2'd0, sel_way};

  always_comb begin
    out_word_nxt.hit           = sel_hit;
    out_word_nxt.total_latency = sel_hit ? {9'd0, hit_latency_r} : lat_sum;
    out_word_nxt.set_index     = set_ext[7:0];
    out_word_nxt.line_tag      = tag_ext[23:0];
    out_word_nxt.filled_way    = way_ext[1:0];
    out_word_nxt.hit_count     = hit_cnt_nxt;
    out_word_nxt.miss_count    = miss_cnt_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hit_cnt_r   <= '0;
      miss_cnt_r  <= '0;
      out_valid_r <= 1'b0;
    end else begin
      hit_cnt_r   <= hit_cnt_nxt;
      miss_cnt_r  <= miss_cnt_nxt;
      out_valid_r <= (state_r == ST_LOOKUP);
    end
  end

  always_ff @(posedge clk) begin
    if (state_r == ST_LOOKUP) begin
      out_word_r <= out_word_nxt;
    end
  end

  assign out_valid = out_valid_r;
  assign out_word  = out_word_r;

  a_accept_interlock: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |=> (busy && state_r == ST_LOOKUP))
    else $error("accepted word not held in lookup");

  a_strobe_after_lookup: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $past(state_r == ST_LOOKUP))
    else $error("result strobe without lookup");

  a_single_strobe: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |=> !out_valid)
    else $error("result strobe longer than one cycle");

  a_hit_keeps_misses: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_word.hit) |-> (miss_cnt_r == $past(miss_cnt_r)))
    else $error("miss counter moved on a hit");

endmodule
